@@ src/aqr_pkg.sv @@
// ----------------------------------------------------------------------------
// aqr_pkg
// Shared widths, operation and status codes, and the slot memory command type
// for the array queue with prefix reverse.
// ----------------------------------------------------------------------------
package aqr_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int DATA_W        = 32;
   localparam int KW            = 9;
   localparam int CAP_W         = 9;
   localparam int STATUS_W      = 3;
   localparam int OP_W          = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   // request codes
   localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
   localparam logic [OP_W-1:0] OP_REV  = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] RSP_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] RSP_EMPTY   = 3'd1;
   localparam logic [STATUS_W-1:0] RSP_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] RSP_INVALID = 3'd3;
   localparam logic [STATUS_W-1:0] RSP_NOREV   = 3'd4;

   // write data source for the slot memory
   localparam logic [1:0] SRC_REQ  = 2'd0;
   localparam logic [1:0] SRC_RD_A = 2'd1;
   localparam logic [1:0] SRC_RD_B = 2'd2;

   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      logic [1:0] wr_src;
   } mem_cmd_type;

endpackage

@@ src/aqr_store.sv @@
// ----------------------------------------------------------------------------
// aqr_store
// Slot memory: two synchronous read ports with registered data, one write
// port whose data comes from the request or from either read port.
// ----------------------------------------------------------------------------
module aqr_store
   import aqr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  mem_cmd_type              cmd,
   input  logic [AW-1:0]            rd_addr_a,
   input  logic [AW-1:0]            rd_addr_b,
   input  logic [AW-1:0]            wr_addr,
   input  logic signed [DATA_W-1:0] req_value,
   output logic signed [DATA_W-1:0] rd_data_a
);

   logic [DATA_W-1:0] slots_ff [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;
   logic [DATA_W-1:0] wr_data;

   // swap writes take the value read from the opposite end
   always_comb begin
      case (cmd.wr_src)
         SRC_RD_A: wr_data = rd_a_ff;
         SRC_RD_B: wr_data = rd_b_ff;
         default:  wr_data = req_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= slots_ff[rd_addr_a];
         rd_b_ff <= slots_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;

endmodule

@@ src/aqr_ctrl.sv @@
// ----------------------------------------------------------------------------
// aqr_ctrl
// Request sequencer: head/tail pointers, capacity register, status decisions,
// swap sequencing for the prefix reverse, and the response register.
// ----------------------------------------------------------------------------
module aqr_ctrl
   import aqr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [OP_W-1:0]            req_type,
   input  logic [KW-1:0]              req_count_k,
   input  logic                       csr_wr_en,
   input  logic [CAP_W-1:0]           csr_wr_data,
   output mem_cmd_type                cmd,
   output logic [AW-1:0]              rd_addr_a,
   output logic [AW-1:0]              rd_addr_b,
   output logic [AW-1:0]              wr_addr,
   input  logic signed [DATA_W-1:0]   rd_data_a,
   output logic                       rsp_strobe,
   output logic signed [DATA_W-1:0]   rsp_data,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam int PTR_W = $clog2(DEPTH + 1);
   localparam int CW    = (PTR_W > KW) ? PTR_W : KW;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WLO  = 2'd1;
   localparam logic [1:0] S_WHI  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [AW-1:0]       lo_ff, lo_in;
   logic [AW-1:0]       hi_ff, hi_in;
   logic [CAP_W-1:0]    cap_ff;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                rsp_use_mem_ff, rsp_use_mem_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [PTR_W-1:0]    used;
   logic                is_full;
   logic                is_empty;
   logic [AW-1:0]       hi_start;
   logic [AW-1:0]       lo_next;
   logic [AW-1:0]       hi_next;
   logic                more_swaps;

   assign used     = tail_ff - head_ff;
   assign is_full  = (CW'(tail_ff) >= CW'(cap_ff)) || (tail_ff == PTR_W'(DEPTH));
   assign is_empty = (head_ff == tail_ff);
   // last index of the prefix; only taken as a swap end when it lies below the tail
   assign hi_start = AW'(CW'(head_ff) + CW'(req_count_k) - CW'(1));
   assign lo_next  = lo_ff + AW'(1);
   assign hi_next  = hi_ff - AW'(1);
   assign more_swaps = (({1'b0, lo_ff} + (AW+1)'(2)) < {1'b0, hi_ff});

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      rsp_strobe_in  = 1'b0;
      rsp_use_mem_in = 1'b0;
      rsp_status_in  = rsp_status_ff;
      cmd            = '0;
      cmd.wr_src     = SRC_REQ;
      wr_addr        = tail_ff[AW-1:0];
      rd_addr_a      = head_ff[AW-1:0];
      rd_addr_b      = hi_start;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.rd_en     = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_status_in = RSP_OK;
               case (req_type)
                  OP_ENQ: begin
                     if (is_full) begin
                        rsp_status_in = RSP_FULL;
                     end else begin
                        cmd.wr_en = 1'b1;
                        tail_in   = tail_ff + PTR_W'(1);
                     end
                  end
                  OP_DEQ, OP_PEEK: begin
                     if (is_empty) begin
                        rsp_status_in = RSP_EMPTY;
                     end else begin
                        rsp_use_mem_in = 1'b1;
                        if (req_type == OP_DEQ) begin
                           head_in = head_ff + PTR_W'(1);
                        end
                     end
                  end
                  default: begin
                     if (req_count_k < KW'(2)) begin
                        rsp_status_in = RSP_NOREV;
                     end else if (CW'(req_count_k) > CW'(used)) begin
                        rsp_status_in = RSP_INVALID;
                     end else begin
                        // both ends are being read now; swap starts next cycle
                        rsp_strobe_in = 1'b0;
                        lo_in         = head_ff[AW-1:0];
                        hi_in         = hi_start;
                        state_in      = S_WLO;
                     end
                  end
               endcase
            end
         end
         S_WLO: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = SRC_RD_B;
            wr_addr    = lo_ff;
            state_in   = S_WHI;
         end
         S_WHI: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = SRC_RD_A;
            wr_addr    = hi_ff;
            lo_in      = lo_next;
            hi_in      = hi_next;
            rd_addr_a  = lo_next;
            rd_addr_b  = hi_next;
            if (more_swaps) begin
               cmd.rd_en = 1'b1;
               state_in  = S_WLO;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = RSP_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         cap_ff         <= CAP_RESET;
         rsp_strobe_ff  <= 1'b0;
         rsp_use_mem_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rsp_use_mem_ff <= rsp_use_mem_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   // read data is only meaningful for a successful dequeue or peek
   assign rsp_data   = rsp_use_mem_ff ? rd_data_a : '0;

endmodule

@@ src/array_queue_with_prefix_reverse.sv @@
// ----------------------------------------------------------------------------
// array_queue_with_prefix_reverse
// Linear array queue with enqueue, dequeue, peek and in-place reversal of the
// first k queued elements.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken when start is high and busy is low. Each
//   request yields exactly one response, shown for one cycle with rsp_strobe
//   high; the receiver has no way to hold it off.
//   Enqueue, dequeue, peek, and any reverse that ends in an error or no-op
//   respond in the cycle after acceptance and leave busy low, so one such
//   request can be issued every cycle.
//   A reverse of k elements swaps both ends of the prefix in the slot memory,
//   floor(k/2) swaps, each one write in S_WLO and one in S_WHI on its single
//   write port; busy stays high until the swaps are done, the response follows
//   the last write, and no new request is taken while busy is high.
//   Head and tail only advance; once the tail reaches the capacity or DEPTH
//   the queue reports full until reset; a larger capacity helps only below DEPTH.
//   The capacity register is written through csr_wr_en/csr_wr_data; the user
//   must write it only while no request is in flight; the block does not enforce it.
//   Synchronous reset empties the queue and sets the capacity to 256; the
//   slot memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module array_queue_with_prefix_reverse
   import aqr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OP_W-1:0]          req_type,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [KW-1:0]            req_count_k,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [STATUS_W-1:0]      rsp_status,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data
);

   localparam int AW = $clog2(DEPTH);

   mem_cmd_type              cmd;
   logic [AW-1:0]            rd_addr_a;
   logic [AW-1:0]            rd_addr_b;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] rd_data_a;

   aqr_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_count_k (req_count_k),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .wr_addr     (wr_addr),
      .rd_data_a   (rd_data_a),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .rsp_status  (rsp_status)
   );

   aqr_store #(
      .DEPTH(DEPTH)
   ) u_store (
      .clock     (clock),
      .cmd       (cmd),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .wr_addr   (wr_addr),
      .req_value (req_value),
      .rd_data_a (rd_data_a)
   );

endmodule

@@ src/aqr_checker.sv @@
// ----------------------------------------------------------------------------
// aqr_checker
// Port-level checks for the array queue with prefix reverse, bound to the
// top level.
// ----------------------------------------------------------------------------
module aqr_checker
   import aqr_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [OP_W-1:0]          req_type,
   input logic                     rsp_strobe,
   input logic signed [DATA_W-1:0] rsp_data,
   input logic [STATUS_W-1:0]      rsp_status
);

   // any request other than a reverse answers on the next cycle
   a_short_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type != OP_REV) |=> rsp_strobe)
      else $error("non-reverse transaction got no response on the next cycle");

   // error and no-op statuses carry zero data
   a_err_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != RSP_OK) |-> (rsp_data == '0))
      else $error("non-ok response with nonzero data");

   // a response comes from an accepted transaction or the end of a swap run
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy) || $past(start))
      else $error("response without a transaction in flight");

   // only a reverse request makes the block busy
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && (req_type == OP_REV)))
      else $error("busy raised without a reverse transaction");

endmodule

bind array_queue_with_prefix_reverse aqr_checker u_aqr_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_type   (req_type),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data),
   .rsp_status (rsp_status)
);
